[rtl/hav_pkg.sv]
// Package for the haversine distance pipeline: word type, fixed-point constants,
// pipeline latencies and the arctangent table function.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hav_pkg;

   // Field widths of the two channels.
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int DIST_W = 25;

   // One 64-bit fixed-point word (Q60 angles, Q62 squares and so on).
   typedef logic [63:0] q60_type;

   localparam q60_type PI_Q60      = 64'h3243F6A8885A308D;
   localparam q60_type HALF_PI_Q60 = PI_Q60 >> 1;
   localparam q60_type ONE_Q60     = 64'd1 << 60;
   localparam q60_type ONE_Q62     = 64'd1 << 62;
   localparam q60_type TWO_R_M     = 64'd12745600;

   // Radians per input unit in Q92: pi in Q60, widened by 32 bits, over 1.8e9.
   localparam logic [127:0] RAD_WIDE = ({64'd0, PI_Q60} << 32) / 128'd1800000000;
   localparam q60_type      RAD_Q92  = RAD_WIDE[63:0];

   // Pipeline geometry.
   localparam int MUL_LAT       = 2;
   localparam int LEVEL_LAT     = 2 * MUL_LAT;
   localparam int HORNER_LEVELS = 13;
   localparam int TRIG_LAT      = MUL_LAT + LEVEL_LAT * HORNER_LEVELS + MUL_LAT + 1;
   localparam int SQRT_STEPS    = 32;
   localparam int VEC_STEPS     = 62;
   localparam int PIPE_DEPTH    = 1 + MUL_LAT + 1 + TRIG_LAT + 2 * MUL_LAT + 2
                                  + SQRT_STEPS + VEC_STEPS + MUL_LAT + 1;

   // Arctangent of 2^-idx in Q60, from the alternating series in Q62.
   function automatic q60_type atan_q60(input int idx);
      q60_type acc;
      q60_type term;
      int      e;
      acc = '0;
      if (idx == 0) begin
         return PI_Q60 >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         e = 62 - idx * (2 * k + 1);
         if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
      end
      return acc >> 2;
   endfunction

endpackage

`default_nettype wire

[rtl/hav_req_if.sv]
// Request channel interface: one item is a pair of points.
// Depends on hav_pkg for the field widths.
`default_nettype none

interface hav_req_if import hav_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] lat_a;
   logic signed [LON_W-1:0] lon_a;
   logic signed [LAT_W-1:0] lat_b;
   logic signed [LON_W-1:0] lon_b;

   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

`default_nettype wire

[rtl/hav_rsp_if.sv]
// Response channel interface: one item is a distance in whole metres.
// Depends on hav_pkg for the field width.
`default_nettype none

interface hav_rsp_if import hav_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_m;

   modport source (output valid, distance_m, input ready);
   modport sink   (input valid, distance_m, output ready);
endinterface

`default_nettype wire

[rtl/hav_mul64.sv]
// Two-stage 64 x 64 unsigned multiplier: four 32 x 32 partial products, then their sum.
// Depends on hav_pkg.
`default_nettype none

module hav_mul64 import hav_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  q60_type       op_a,
   input  q60_type       op_b,
   output logic [127:0]  prod
);

   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [127:0] prod_ff;

   // First stage: partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= op_a[31:0]  * op_b[31:0];
         pp01_ff <= op_a[31:0]  * op_b[63:32];
         pp10_ff <= op_a[63:32] * op_b[31:0];
         pp11_ff <= op_a[63:32] * op_b[63:32];
      end
   end

   // Second stage: weighted sum of the partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {pp11_ff, pp00_ff} + ({64'd0, pp01_ff} << 32) + ({64'd0, pp10_ff} << 32);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[rtl/hav_trig.sv]
// Sine or cosine of a Q60 angle in [0, pi/2] by a Horner series, one level per four stages.
// Depends on hav_pkg and hav_mul64.
`default_nettype none

module hav_trig import hav_pkg::*; #(
   parameter bit IS_COS = 1'b0
) (
   input  logic    clock,
   input  logic    en,
   input  q60_type angle,
   output q60_type result
);

   localparam int NLEV = IS_COS ? HORNER_LEVELS - 1 : HORNER_LEVELS;
   localparam int PAD  = LEVEL_LAT * (HORNER_LEVELS - NLEV);

   logic [127:0] sq_prod;
   logic [127:0] fin_prod;
   q60_type      fin_val;
   q60_type      lvl_f  [0:NLEV];
   q60_type      lvl_t2 [0:NLEV];
   q60_type      out_ff [0:PAD];

   // Square of the angle feeds every level.
   hav_mul64 u_sq (
      .clock (clock), .en (en), .op_a (angle), .op_b (angle), .prod (sq_prod)
   );

   assign lvl_f[0]  = ONE_Q60;
   assign lvl_t2[0] = 64'(sq_prod >> 60);

   // Each level forms f = 1 - t2*f / d, the division done by a reciprocal multiply.
   for (genvar j = 0; j < NLEV; j++) begin : g_lvl
      localparam int K  = HORNER_LEVELS - j;
      localparam int D  = IS_COS ? (2 * K - 1) * (2 * K) : (2 * K) * (2 * K + 1);
      localparam int L  = $clog2(D);
      localparam int SH = 62 + L;
      localparam logic [127:0] RECIP = ((128'd1 << SH) / D) + 128'd1;

      logic [127:0] pa, pb;
      q60_type      xa;
      q60_type      t2d_ff [0:LEVEL_LAT-1];

      hav_mul64 u_fm (
         .clock (clock), .en (en), .op_a (lvl_t2[j]), .op_b (lvl_f[j]), .prod (pa)
      );

      assign xa = 64'(pa >> 60);

      hav_mul64 u_dv (
         .clock (clock), .en (en), .op_a (xa), .op_b (RECIP[63:0]), .prod (pb)
      );

      // The square travels beside the level.
      always_ff @(posedge clock) begin
         if (en) begin
            t2d_ff[0] <= lvl_t2[j];
            for (int i = 1; i < LEVEL_LAT; i++) begin
               t2d_ff[i] <= t2d_ff[i-1];
            end
         end
      end

      assign lvl_f[j+1]  = ONE_Q60 - 64'(pb >> SH);
      assign lvl_t2[j+1] = t2d_ff[LEVEL_LAT-1];
   end

   // Final multiply: t*f for the sine, 1 - t2*f/2 clamped at zero for the cosine.
   if (IS_COS) begin : g_cos
      q60_type g;

      hav_mul64 u_fin (
         .clock (clock), .en (en), .op_a (lvl_t2[NLEV]), .op_b (lvl_f[NLEV]),
         .prod (fin_prod)
      );

      assign g       = 64'(fin_prod >> 61);
      assign fin_val = (g >= ONE_Q60) ? '0 : ONE_Q60 - g;
   end else begin : g_sin
      localparam int ADLY = MUL_LAT + LEVEL_LAT * NLEV;

      q60_type ang_ff [0:ADLY-1];

      always_ff @(posedge clock) begin
         if (en) begin
            ang_ff[0] <= angle;
            for (int i = 1; i < ADLY; i++) begin
               ang_ff[i] <= ang_ff[i-1];
            end
         end
      end

      hav_mul64 u_fin (
         .clock (clock), .en (en), .op_a (ang_ff[ADLY-1]), .op_b (lvl_f[NLEV]),
         .prod (fin_prod)
      );

      assign fin_val = 64'(fin_prod >> 60);
   end

   // Output register, padded so that sine and cosine share one latency.
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff[0] <= fin_val;
         for (int p = 1; p <= PAD; p++) begin
            out_ff[p] <= out_ff[p-1];
         end
      end
   end

   assign result = out_ff[PAD];

endmodule

`default_nettype wire

[rtl/hav_isqrt.sv]
// Integer square root of a 64-bit word, one result bit per pipeline stage.
// Depends on hav_pkg.
`default_nettype none

module hav_isqrt import hav_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  q60_type     radicand,
   output logic [31:0] root
);

   q60_type v_ff [0:SQRT_STEPS-1];
   q60_type r_ff [0:SQRT_STEPS-1];

   // Each stage tries one bit pair of the remainder.
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam q60_type BIT = 64'd1 << (62 - 2 * j);

      q60_type v_prev, r_prev, cand;

      if (j == 0) begin : g_first
         assign v_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[j-1];
         assign r_prev = r_ff[j-1];
      end

      assign cand = r_prev + BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (v_prev >= cand) begin
               v_ff[j] <= v_prev - cand;
               r_ff[j] <= (r_prev >> 1) + BIT;
            end else begin
               v_ff[j] <= v_prev;
               r_ff[j] <= r_prev >> 1;
            end
         end
      end
   end

   assign root = r_ff[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

[rtl/hav_cordic.sv]
// CORDIC vectoring pipeline: angle of (x, y) in Q60, one rotation per stage.
// Depends on hav_pkg for the word type and the arctangent table.
`default_nettype none

module hav_cordic import hav_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  q60_type x_start,
   input  q60_type y_start,
   output q60_type angle
);

   q60_type x_ff [0:VEC_STEPS-1];
   q60_type y_ff [0:VEC_STEPS-1];
   q60_type z_ff [0:VEC_STEPS-1];

   // Rotate towards y = 0, accumulating the angle turned.
   for (genvar i = 0; i < VEC_STEPS; i++) begin : g_rot
      localparam q60_type ATAN = atan_q60(i);

      q60_type x_prev, y_prev, z_prev, xs, ys;

      if (i == 0) begin : g_first
         assign x_prev = x_start;
         assign y_prev = y_start;
         assign z_prev = '0;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      assign xs = x_prev >> i;
      assign ys = 64'($signed(y_prev) >>> i);

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_prev[63]) begin
               x_ff[i] <= x_prev + ys;
               y_ff[i] <= y_prev - xs;
               z_ff[i] <= z_prev + ATAN;
            end else begin
               x_ff[i] <= x_prev - ys;
               y_ff[i] <= y_prev + xs;
               z_ff[i] <= z_prev - ATAN;
            end
         end
      end
   end

   // A negative residual angle reads as zero.
   assign angle = z_ff[VEC_STEPS-1][63] ? '0 : z_ff[VEC_STEPS-1];

endmodule

`default_nettype wire

[rtl/haversine_distance_meters_top.sv]
// Top level of the haversine distance pipeline: input conversion, trigonometry,
// square roots, arcsine by CORDIC, scaling, and the output register with skid stage.
// Depends on hav_pkg, hav_req_if, hav_rsp_if, hav_mul64, hav_trig, hav_isqrt, hav_cordic.
`default_nettype none

// The block takes one pair of points in every cycle while it holds ready high and returns
// the great-circle distance in whole metres; items leave in the order they came. The
// length of the pipeline is set mostly by the thirteen-level Horner series (four
// stages a level), the 32-step square root and the 62-step CORDIC arcsine. When the
// response side stalls, one finished item waits in the output register and one in a
// skid stage; once both are full the whole pipeline holds and the request side sees
// ready low until the skid drains.

module haversine_distance_meters_top import hav_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   hav_req_if.sink        req_ch,
   hav_rsp_if.source      rsp_ch
);

   // Angle folding for the sine: only its magnitude is needed.
   function automatic q60_type fold_sin(input q60_type t);
      q60_type u;
      if (t > PI_Q60) begin
         u = t - PI_Q60;
      end else if (t > HALF_PI_Q60) begin
         u = PI_Q60 - t;
      end else begin
         u = t;
      end
      if (u > HALF_PI_Q60) begin
         u = HALF_PI_Q60;
      end
      return u;
   endfunction

   // Angle folding for the cosine; the sign is handled separately.
   function automatic q60_type fold_cos(input q60_type t);
      q60_type u;
      u = (t > PI_Q60) ? PI_Q60 : t;
      if (u > HALF_PI_Q60) begin
         u = PI_Q60 - u;
      end
      return u;
   endfunction

   localparam int NEG_DLY = TRIG_LAT + 2 * MUL_LAT;

   logic                  pipe_en;
   logic [PIPE_DEPTH-1:0] vld_ff;

   logic signed [32:0]    dlat, dlon;
   logic signed [31:0]    la_ext, lb_ext;
   logic [31:0]           mdlat_ff;
   logic [32:0]           mdlon_ff;
   logic [30:0]           mla_ff, mlb_ff;

   logic [127:0]          p_hlat, p_hlon, p_la, p_lb;
   q60_type               hlat, hlon, lar, lbr;
   q60_type               fs1_ff, fs2_ff, fc1_ff, fc2_ff;
   logic                  nx_ff;
   logic [NEG_DLY-1:0]    nx_dly_ff;

   q60_type               s1, s2, c1, c2;
   logic [127:0]          p_t1, p_t2, p_cc, p_q;
   q60_type               t1, t2s, pc, qv;
   q60_type               t1_d_ff [0:MUL_LAT-1];
   q60_type               a_in, a_ff, sa_ff, sb_ff;

   logic [31:0]           sv, tv;
   q60_type               zang;
   logic [127:0]          p_dist;
   logic [DIST_W-1:0]     res_ff;

   logic                  take;
   logic                  out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [DIST_W-1:0]     out_dist_ff, out_dist_in, skid_dist_ff, skid_dist_in;

   // The whole pipeline moves while the skid stage is empty.
   assign pipe_en      = !skid_vld_ff;
   assign req_ch.ready = pipe_en;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};
      end
   end

   // Differences and magnitudes of the coordinates.
   assign dlat   = 33'(req_ch.lat_b) - 33'(req_ch.lat_a);
   assign dlon   = 33'(req_ch.lon_b) - 33'(req_ch.lon_a);
   assign la_ext = 32'(req_ch.lat_a);
   assign lb_ext = 32'(req_ch.lat_b);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mdlat_ff <= 32'(dlat[32] ? -dlat : dlat);
         mdlon_ff <= dlon[32] ? 33'(-dlon) : 33'(dlon);
         mla_ff   <= 31'(la_ext[31] ? -la_ext : la_ext);
         mlb_ff   <= 31'(lb_ext[31] ? -lb_ext : lb_ext);
      end
   end

   // Conversion to Q60 radians: halves of the differences, whole latitudes.
   hav_mul64 u_cv_dlat (
      .clock (clock), .en (pipe_en), .op_a (64'(mdlat_ff)), .op_b (RAD_Q92), .prod (p_hlat)
   );
   hav_mul64 u_cv_dlon (
      .clock (clock), .en (pipe_en), .op_a (64'(mdlon_ff)), .op_b (RAD_Q92), .prod (p_hlon)
   );
   hav_mul64 u_cv_la (
      .clock (clock), .en (pipe_en), .op_a (64'(mla_ff)), .op_b (RAD_Q92), .prod (p_la)
   );
   hav_mul64 u_cv_lb (
      .clock (clock), .en (pipe_en), .op_a (64'(mlb_ff)), .op_b (RAD_Q92), .prod (p_lb)
   );

   assign hlat = 64'(p_hlat >> 33);
   assign hlon = 64'(p_hlon >> 33);
   assign lar  = 64'(p_la >> 32);
   assign lbr  = 64'(p_lb >> 32);

   // Fold the angles into the first quadrant; note whether the cosines differ in sign.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fs1_ff <= fold_sin(hlat);
         fs2_ff <= fold_sin(hlon);
         fc1_ff <= fold_cos(lar);
         fc2_ff <= fold_cos(lbr);
         nx_ff  <= (lar > HALF_PI_Q60) ^ (lbr > HALF_PI_Q60);
      end
   end

   // Sign difference waits for the combining stage.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nx_dly_ff <= {nx_dly_ff[NEG_DLY-2:0], nx_ff};
      end
   end

   hav_trig #(.IS_COS (1'b0)) u_sin_lat (
      .clock (clock), .en (pipe_en), .angle (fs1_ff), .result (s1)
   );
   hav_trig #(.IS_COS (1'b0)) u_sin_lon (
      .clock (clock), .en (pipe_en), .angle (fs2_ff), .result (s2)
   );
   hav_trig #(.IS_COS (1'b1)) u_cos_a (
      .clock (clock), .en (pipe_en), .angle (fc1_ff), .result (c1)
   );
   hav_trig #(.IS_COS (1'b1)) u_cos_b (
      .clock (clock), .en (pipe_en), .angle (fc2_ff), .result (c2)
   );

   // Squares of the sines in Q62 and the cosine product in Q60.
   hav_mul64 u_sq1 (
      .clock (clock), .en (pipe_en), .op_a (s1), .op_b (s1), .prod (p_t1)
   );
   hav_mul64 u_sq2 (
      .clock (clock), .en (pipe_en), .op_a (s2), .op_b (s2), .prod (p_t2)
   );
   hav_mul64 u_cc (
      .clock (clock), .en (pipe_en), .op_a (c1), .op_b (c2), .prod (p_cc)
   );

   assign t1  = 64'(p_t1 >> 58);
   assign t2s = 64'(p_t2 >> 58);
   assign pc  = 64'(p_cc >> 60);

   hav_mul64 u_q (
      .clock (clock), .en (pipe_en), .op_a (t2s), .op_b (pc), .prod (p_q)
   );

   assign qv = 64'(p_q >> 60);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1_d_ff[0] <= t1;
         for (int i = 1; i < MUL_LAT; i++) begin
            t1_d_ff[i] <= t1_d_ff[i-1];
         end
      end
   end

   // Haversine sum, clamped to the range [0, 1] in Q62.
   always_comb begin
      if (nx_dly_ff[NEG_DLY-1]) begin
         a_in = (qv > t1_d_ff[MUL_LAT-1]) ? '0 : t1_d_ff[MUL_LAT-1] - qv;
      end else begin
         a_in = t1_d_ff[MUL_LAT-1] + qv;
      end
      if (a_in > ONE_Q62) begin
         a_in = ONE_Q62;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_ff  <= a_in;
         sa_ff <= a_ff;
         sb_ff <= ONE_Q62 - a_ff;
      end
   end

   // Square roots of a and 1 - a in Q31.
   hav_isqrt u_sqrt_a (
      .clock (clock), .en (pipe_en), .radicand (sa_ff), .root (sv)
   );
   hav_isqrt u_sqrt_b (
      .clock (clock), .en (pipe_en), .radicand (sb_ff), .root (tv)
   );

   // Arcsine of sqrt(a) as the angle of (sqrt(1 - a), sqrt(a)).
   hav_cordic u_asin (
      .clock   (clock),
      .en      (pipe_en),
      .x_start (64'(tv) << 29),
      .y_start (64'(sv) << 29),
      .angle   (zang)
   );

   // Scale by twice the radius and round half up to whole metres.
   hav_mul64 u_scale (
      .clock (clock), .en (pipe_en), .op_a (zang), .op_b (TWO_R_M), .prod (p_dist)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff <= DIST_W'((p_dist + (128'd1 << 59)) >> 60);
      end
   end

   // Output register and skid stage.
   assign take = out_vld_ff & rsp_ch.ready;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_dist_in  = out_dist_ff;
      skid_vld_in  = skid_vld_ff;
      skid_dist_in = skid_dist_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_dist_in = skid_dist_ff;
            skid_vld_in = 1'b0;
         end
      end else if (vld_ff[PIPE_DEPTH-1]) begin
         if (!out_vld_ff || take) begin
            out_vld_in  = 1'b1;
            out_dist_in = res_ff;
         end else begin
            skid_vld_in  = 1'b1;
            skid_dist_in = res_ff;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_dist_ff  <= out_dist_in;
      skid_dist_ff <= skid_dist_in;
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.distance_m = out_dist_ff;

endmodule

`default_nettype wire

[verif/haversine_distance_meters_top_test.sv]
// Testbench for the haversine distance pipeline: directed pairs of points, then random
// pairs, each distance checked in order against a known value or a bit-exact fixed-point predictor.
// Depends on hav_pkg, hav_req_if, hav_rsp_if and haversine_distance_meters_top.
`default_nettype none

module haversine_distance_meters_top_test;
   import hav_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 400;
   localparam int RANDOM_PAIRS   = 1200;
   localparam int NO_VALUE       = -1;

   typedef struct {
      logic signed [LAT_W-1:0] lat_a;
      logic signed [LON_W-1:0] lon_a;
      logic signed [LAT_W-1:0] lat_b;
      logic signed [LON_W-1:0] lon_b;
      int                      known_m;
   } pair_row_type;

   logic clock;
   logic reset;

   hav_req_if req_ch ();
   hav_rsp_if rsp_ch ();

   haversine_distance_meters_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [DIST_W-1:0] distance_queue[$];
   int                pending_known[$];
   int                error_count;
   int                idle_cycles;
   q60_type           arctan_table[VEC_STEPS];
   q60_type           rad_per_unit;

   // Clock.
   initial begin
      clock = 1'b0;
   end
   always begin
      #10 clock = ~clock;
   end

   // Arctangent table and radian factor, worked out once.
   initial begin
      logic [127:0] wide;
      q60_type      acc;
      int           e;
      wide = ({64'd0, PI_Q60} << 32) / 128'd1800000000;
      rad_per_unit = wide[63:0];
      arctan_table[0] = PI_Q60 >> 2;
      for (int i = 1; i < VEC_STEPS; i++) begin
         acc = '0;
         for (int k = 0; k < 40; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
               if (k % 2 == 1) begin
                  acc = acc - ((64'd1 << e) / 64'(2 * k + 1));
               end else begin
                  acc = acc + ((64'd1 << e) / 64'(2 * k + 1));
               end
            end
         end
         arctan_table[i] = acc >> 2;
      end
   end

   function automatic q60_type mul_shift(input q60_type a, input q60_type b, input int sh);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod >> sh;
      return prod[63:0];
   endfunction

   function automatic q60_type abs_diff(input longint d);
      return (d < 0) ? q60_type'(-d) : q60_type'(d);
   endfunction

   // Sine and cosine on [0, pi/2] by a truncating Horner series.
   function automatic q60_type sine_q60(input q60_type t);
      q60_type sq;
      q60_type f;
      sq = mul_shift(t, t, 60);
      f = ONE_Q60;
      for (int k = HORNER_LEVELS; k >= 1; k--) begin
         f = ONE_Q60 - mul_shift(sq, f, 60) / q60_type'((2 * k) * (2 * k + 1));
      end
      return mul_shift(t, f, 60);
   endfunction

   function automatic q60_type cosine_q60(input q60_type t);
      q60_type sq;
      q60_type f;
      q60_type g;
      sq = mul_shift(t, t, 60);
      f = ONE_Q60;
      for (int k = HORNER_LEVELS; k >= 2; k--) begin
         f = ONE_Q60 - mul_shift(sq, f, 60) / q60_type'((2 * k - 1) * (2 * k));
      end
      g = mul_shift(sq, f, 60) >> 1;
      return (g >= ONE_Q60) ? '0 : ONE_Q60 - g;
   endfunction

   function automatic q60_type abs_sine(input q60_type t);
      if (t > PI_Q60) begin
         t = t - PI_Q60;
      end else if (t > HALF_PI_Q60) begin
         t = PI_Q60 - t;
      end
      if (t > HALF_PI_Q60) begin
         t = HALF_PI_Q60;
      end
      return sine_q60(t);
   endfunction

   // Cosine magnitude; the flag says that the true cosine is negative.
   function automatic q60_type cosine_mag(input q60_type t, output logic negative);
      negative = 1'b0;
      if (t > PI_Q60) begin
         t = PI_Q60;
      end
      if (t > HALF_PI_Q60) begin
         t = PI_Q60 - t;
         negative = 1'b1;
      end
      return cosine_q60(t);
   endfunction

   function automatic q60_type int_sqrt(input q60_type v);
      q60_type root;
      q60_type bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Angle of the vector (x, y) by CORDIC vectoring, Q60, negative clamped to 0.
   function automatic q60_type vector_angle(input q60_type x, input q60_type y);
      q60_type z;
      q60_type xs;
      logic signed [63:0] ys;
      z = '0;
      for (int i = 0; i < VEC_STEPS; i++) begin
         xs = x >> i;
         ys = $signed(y) >>> i;
         if (!y[63]) begin
            x = x + q60_type'(ys);
            y = y - xs;
            z = z + arctan_table[i];
         end else begin
            x = x - q60_type'(ys);
            y = y + xs;
            z = z - arctan_table[i];
         end
      end
      return z[63] ? '0 : z;
   endfunction

   function automatic logic [DIST_W-1:0] great_circle_m(input pair_row_type p);
      longint       la, oa, lb, ob;
      q60_type      s1, s2, c1, c2, t1, t2, prod, q, a, sv, tv, z;
      logic         n1, n2;
      logic [127:0] wide;
      la = longint'(p.lat_a);
      oa = longint'(p.lon_a);
      lb = longint'(p.lat_b);
      ob = longint'(p.lon_b);
      s1 = abs_sine(mul_shift(abs_diff(lb - la), rad_per_unit, 33));
      s2 = abs_sine(mul_shift(abs_diff(ob - oa), rad_per_unit, 33));
      c1 = cosine_mag(mul_shift(abs_diff(la), rad_per_unit, 32), n1);
      c2 = cosine_mag(mul_shift(abs_diff(lb), rad_per_unit, 32), n2);
      t1 = mul_shift(s1, s1, 58);
      t2 = mul_shift(s2, s2, 58);
      prod = mul_shift(c1, c2, 60);
      q = mul_shift(t2, prod, 60);
      if (n1 ^ n2) begin
         a = (q > t1) ? '0 : t1 - q;
      end else begin
         a = t1 + q;
      end
      if (a > ONE_Q62) begin
         a = ONE_Q62;
      end
      sv = int_sqrt(a);
      tv = int_sqrt(ONE_Q62 - a);
      z = vector_angle(tv << 29, sv << 29);
      wide = {64'd0, z} * {64'd0, TWO_R_M} + (128'd1 << 59);
      wide = wide >> 60;
      return wide[DIST_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // Predict on every accepted request, check every accepted response.
   always @(posedge clock) begin
      pair_row_type      p;
      logic [DIST_W-1:0] want;
      int                known;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            p.lat_a = req_ch.lat_a;
            p.lon_a = req_ch.lon_a;
            p.lat_b = req_ch.lat_b;
            p.lon_b = req_ch.lon_b;
            known = (pending_known.size() > 0) ? pending_known.pop_front() : NO_VALUE;
            if (known == NO_VALUE) begin
               distance_queue = {distance_queue, great_circle_m(p)};
            end else begin
               distance_queue = {distance_queue, DIST_W'(known)};
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (distance_queue.size() == 0) begin
               report_mismatch($sformatf("distance %0d with none expected",
                                         rsp_ch.distance_m));
            end else begin
               want = distance_queue.pop_front();
               if (rsp_ch.distance_m !== want) begin
                  report_mismatch($sformatf("distance_m %0d, expected %0d",
                                            rsp_ch.distance_m, want));
               end
            end
         end
      end
   end

   // Receiver stalls: a randomly drawn mode, from always ready to long stalls.
   always @(posedge clock) begin
      int unsigned mode_count;
      int unsigned mode;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         mode_count <= 0;
         mode <= 0;
      end else begin
         mode_count <= mode_count + 1;
         if (mode_count % 64 == 63) begin
            mode <= $urandom_range(3);
         end
         case (mode)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= 1'($urandom_range(1));
            end
            2: begin
               rsp_ch.ready <= ($urandom_range(7) == 0);
            end
            default: begin
               rsp_ch.ready <= (mode_count % 32) < 24;
            end
         endcase
      end
   end

   // Watchdog on cycles with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // One item: hold valid until the handshake.
   task automatic send_pair(input pair_row_type p);
      pending_known = {pending_known, p.known_m};
      req_ch.valid <= 1'b1;
      req_ch.lat_a <= p.lat_a;
      req_ch.lon_a <= p.lon_a;
      req_ch.lat_b <= p.lat_b;
      req_ch.lon_b <= p.lon_b;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic signed [LAT_W-1:0] any_lat();
      return LAT_W'($urandom_range(1800000000) - 900000000);
   endfunction

   function automatic logic signed [LON_W-1:0] any_lon();
      return $urandom_range(32'd3600000000) - 32'd1800000000;
   endfunction

   // Random pair: mostly true coordinates, some identical or near points,
   // some raw bit patterns and range extremes.
   function automatic pair_row_type random_pair();
      pair_row_type p;
      int unsigned  pick;
      pick = $urandom_range(99);
      p.known_m = NO_VALUE;
      p.lat_a = any_lat();
      p.lon_a = any_lon();
      p.lat_b = any_lat();
      p.lon_b = any_lon();
      if (pick < 10) begin
         p.lat_b = p.lat_a;
         p.lon_b = p.lon_a;
      end else if (pick < 25) begin
         p.lat_b = LAT_W'(p.lat_a + $signed($urandom_range(20000)) - 10000);
         p.lon_b = LON_W'(p.lon_a + $signed($urandom_range(20000)) - 10000);
      end else if (pick < 38) begin
         p.lat_a = LAT_W'($urandom);
         p.lon_a = $urandom;
         p.lat_b = LAT_W'($urandom);
         p.lon_b = $urandom;
      end else if (pick < 45) begin
         p.lat_a = LAT_W'($urandom_range(1) ? 900000000 : -900000000);
         p.lon_b = $urandom_range(1) ? 1800000000 : -1800000000;
      end
      return p;
   endfunction

   // Directed pairs; a known distance is given only where it is plain.
   pair_row_type directed_rows[] = '{
      '{0, 0, 0, 0, 0},
      '{900000000, 1800000000, 900000000, 1800000000, 0},
      '{-900000000, -1800000000, -900000000, -1800000000, 0},
      '{-31'sd1073741824, -32'sd2147483648, -31'sd1073741824, -32'sd2147483648, 0},
      '{0, 0, 0, 1800000000, NO_VALUE},
      '{900000000, 0, -900000000, 0, NO_VALUE},
      '{0, -1800000000, 0, 1800000000, NO_VALUE},
      '{0, 0, 1, 0, NO_VALUE},
      '{0, 0, 0, 1, NO_VALUE},
      '{515007000, -1246000, 407128000, -740060000, NO_VALUE},
      '{31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648, NO_VALUE},
      '{1000000000, 0, -1000000000, 100000000, NO_VALUE},
      '{0, -32'sd2147483648, 0, 32'sd2147483647, NO_VALUE},
      '{-31'sd1073741824, 0, 31'sd1073741823, 0, NO_VALUE},
      '{450000000, 900000000, -450000000, -900000000, NO_VALUE},
      '{899999999, 1234567, 899999999, -1234567, NO_VALUE}
   };

   // Stimulus and end of run.
   initial begin
      int burst;
      error_count = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.lat_a = '0;
      req_ch.lon_a = '0;
      req_ch.lat_b = '0;
      req_ch.lon_b = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i]);
         sender_gap($urandom_range(1) ? 0 : $urandom_range(3));
      end

      // Random pairs in bursts; halfway the sender waits for the pipeline to empty.
      for (int n = 0; n < RANDOM_PAIRS; n += burst) begin
         burst = $urandom_range(40, 1);
         for (int j = 0; j < burst; j++) begin
            send_pair(random_pair());
         end
         if (n < RANDOM_PAIRS / 2 && n + burst >= RANDOM_PAIRS / 2) begin
            req_ch.valid <= 1'b0;
            while (distance_queue.size() > 0 || pending_known.size() > 0) begin
               @(posedge clock);
            end
         end else begin
            sender_gap($urandom_range(3) == 0 ? 0 : $urandom_range(12));
         end
      end
      req_ch.valid <= 1'b0;

      while (distance_queue.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && distance_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
